[hw/rtl/fpsd_pkg.sv]
// ----------------------------------------------------------------------------
// fpsd_pkg
// Types and constants for the saturating fixed-point divider.
// ----------------------------------------------------------------------------
package fpsd_pkg;

  localparam int unsigned DataW       = 32;
  // Unsaturated quotient magnitudes stay below 2^(DataW-2).
  localparam int unsigned QuotW       = DataW - 2;
  localparam int unsigned FracBitsDef = 16;

  localparam logic [DataW-1:0] SatPos = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SatNeg = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic signed [DataW-1:0] dividend;
    logic signed [DataW-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] quotient;
    logic                    saturated;
  } out_t;

endpackage

[hw/rtl/fixed_point_saturating_divide.sv]
// ----------------------------------------------------------------------------
// fixed_point_saturating_divide
// Pipelined signed fixed-point divider with overflow guard and saturation.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------------
//  in      | in_valid_i / in_ready_o   / in_i  | dividend, divisor
//  out     | out_valid_o / out_ready_i / out_o | quotient, saturated
//
//  One item per cycle while the output is not held; the pipe has one front
//  stage, one restoring step per stage and one sign stage.
//  Reset clears only the valid bits; payload registers are left as they are.
//  A result held at the output freezes the whole pipe and drops in_ready_o.
// ----------------------------------------------------------------------------
module fixed_point_saturating_divide #(
  parameter int unsigned FracBits = fpsd_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fpsd_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fpsd_pkg::out_t out_o
);
  import fpsd_pkg::*;

  localparam int unsigned GuardShift = QuotW - FracBits;
  localparam int unsigned NumSteps   = QuotW;

  logic                  adv;
  logic [DataW-1:0]      mag_a, mag_b;
  logic                  neg_d, sat_d;

  logic [NumSteps:0]     vld_q;
  logic [DataW-1:0]      rem_q [0:NumSteps];
  logic [DataW-1:0]      den_q [0:NumSteps];
  logic [QuotW-1:0]      quo_q [0:NumSteps];
  logic [GuardShift-1:0] low_q [0:NumSteps];
  logic [NumSteps:0]     neg_q;
  logic [NumSteps:0]     sat_q;

  logic                  out_vld_q;
  out_t                  out_q, out_d;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // front stage: magnitudes and guard
  always_comb begin
    mag_a = in_i.dividend[DataW-1] ? (DataW'(0) - $unsigned(in_i.dividend))
                                   : $unsigned(in_i.dividend);
    mag_b = in_i.divisor[DataW-1] ? (DataW'(0) - $unsigned(in_i.divisor))
                                  : $unsigned(in_i.divisor);
    neg_d = in_i.dividend[DataW-1] ^ in_i.divisor[DataW-1];
    sat_d = (mag_a >> GuardShift) >= mag_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= mag_a >> GuardShift;
      den_q[0] <= mag_b;
      quo_q[0] <= '0;
      low_q[0] <= mag_a[GuardShift-1:0];
      neg_q[0] <= neg_d;
      sat_q[0] <= sat_d;
    end
  end

  // one restoring step per stage
  for (genvar s = 0; s < NumSteps; s++) begin : g_step
    logic            fb;
    logic [DataW:0]  trial;
    logic [DataW:0]  diff;
    logic            take;
    logic [DataW-1:0] rem_d;

    if (s < GuardShift) begin : g_low
      assign fb = low_q[s][GuardShift-1-s];
    end else begin : g_zero
      assign fb = 1'b0;
    end

    always_comb begin
      trial = {rem_q[s], fb};
      diff  = trial - {1'b0, den_q[s]};
      take  = trial >= {1'b0, den_q[s]};
      rem_d = take ? diff[DataW-1:0] : trial[DataW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[s+1] <= rem_d;
        den_q[s+1] <= den_q[s];
        quo_q[s+1] <= {quo_q[s][QuotW-2:0], take};
        low_q[s+1] <= low_q[s];
        neg_q[s+1] <= neg_q[s];
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  // sign stage
  always_comb begin
    logic [DataW-1:0] mag_q;
    mag_q = {{(DataW-QuotW){1'b0}}, quo_q[NumSteps]};
    if (sat_q[NumSteps]) begin
      out_d.quotient = neg_q[NumSteps] ? SatNeg : SatPos;
    end else begin
      out_d.quotient = neg_q[NumSteps] ? (DataW'(0) - mag_q) : mag_q;
    end
    out_d.saturated = sat_q[NumSteps];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.saturated |->
      (out_o.quotient == SatPos) || (out_o.quotient == SatNeg))
    else $error("saturated item without a saturation value");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.saturated |->
      out_o.quotient[DataW-1] == out_o.quotient[DataW-2])
    else $error("unsaturated quotient out of range");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !sat_q[0] |-> rem_q[0] < den_q[0])
    else $error("partial remainder not below divisor");

  a_rem_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumSteps] && !sat_q[NumSteps] |-> rem_q[NumSteps] < den_q[NumSteps])
    else $error("final remainder not below divisor");
`endif

endmodule
